>>> sv/cda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and calendar functions for the date advance block.
// ----------------------------------------------------------------------------
package cda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int CNT_W   = 10;

    localparam logic [YEAR_W-1:0]  YEAR_LAST   = 14'd9999;
    localparam logic [CNT_W-1:0]   MAX_ADVANCE = 10'd1023;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;

    // multiplicative inverse of 25 modulo 2^14, and the largest product
    // that marks a multiple of 25 (floor((2^14 - 1) / 25))
    localparam logic [YEAR_W-1:0] INV25 = 14'd7209;
    localparam logic [YEAR_W-1:0] LIM25 = 14'd655;

    // calendar date, fields in comparison order
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // controller to datapath commands
    typedef struct packed {
        logic start;    // take the input item: load date if requested, load day count
        logic step;     // advance one day, count down
        logic capture;  // write the result register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic count_zero;
    } sts_t;

    // leap year: divisible by 400, or by 4 but not by 100
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = y * INV25;
        div25 = (prod <= LIM25);
        return div25 ? (y[3:0] == 4'd0) : (y[1:0] == 2'd0);
    endfunction

    // month length; months outside 1..12 count as 31 days
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

>>> sv/cda_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_in_if / cda_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface cda_in_if;
    import cda_pkg::*;

    logic               valid;
    logic               ready;
    logic               load;
    logic [YEAR_W-1:0]  load_year;
    logic [MONTH_W-1:0] load_month;
    logic [DAY_W-1:0]   load_day;
    logic [CNT_W-1:0]   advance_days;

    modport source (output valid, load, load_year, load_month, load_day, advance_days,
                    input ready);
    modport sink   (input valid, load, load_year, load_month, load_day, advance_days,
                    output ready);
endinterface

interface cda_out_if;
    import cda_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  cur_year_out;
    logic [MONTH_W-1:0] cur_month_out;
    logic [DAY_W-1:0]   cur_day_out;
    logic               before_reference;
    logic               after_reference;
    logic               equal_reference;

    modport source (output valid, cur_year_out, cur_month_out, cur_day_out,
                    before_reference, after_reference, equal_reference,
                    input ready);
    modport sink   (input valid, cur_year_out, cur_month_out, cur_day_out,
                    before_reference, after_reference, equal_reference,
                    output ready);
endinterface
`default_nettype wire

>>> sv/cda_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_regs
// APB register file holding the reference date.
// ----------------------------------------------------------------------------
module cda_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready,
    output cda_pkg::date_t      ref_date
);
    import cda_pkg::*;

    typedef enum logic [1:0] {
        REG_YEAR  = 2'd0,
        REG_MONTH = 2'd1,
        REG_DAY   = 2'd2
    } reg_idx_t;

    date_t ref_reg;
    logic  wr_en;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign ref_date = ref_reg;

    // write the addressed register, drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg.year  <= 14'd2000;
            ref_reg.month <= 4'd1;
            ref_reg.day   <= 5'd1;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_YEAR:  ref_reg.year  <= pwdata[YEAR_W-1:0];
                REG_MONTH: ref_reg.month <= pwdata[MONTH_W-1:0];
                REG_DAY:   ref_reg.day   <= pwdata[DAY_W-1:0];
                default:   ;
            endcase
        end
    end

    // read back the addressed register
    always_comb
    begin
        case (paddr[3:2])
            REG_YEAR:  prdata = {{(32-YEAR_W){1'b0}}, ref_reg.year};
            REG_MONTH: prdata = {{(32-MONTH_W){1'b0}}, ref_reg.month};
            REG_DAY:   prdata = {{(32-DAY_W){1'b0}}, ref_reg.day};
            default:   prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/cda_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_ctrl
// Controller: takes items, sequences the day steps, hands off results.
// ----------------------------------------------------------------------------
module cda_ctrl (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire cda_pkg::sts_t sts,
    output cda_pkg::cmd_t   cmd
);
    import cda_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // decode commands from the state and the handshakes
    always_comb
    begin
        cmd.start   = (state_reg == ST_IDLE) && in_valid;
        cmd.step    = (state_reg == ST_RUN) && !sts.count_zero;
        cmd.capture = (state_reg == ST_RUN) && sts.count_zero && slot_free;
    end

    // advance the state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (cmd.capture)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // hold the result valid until taken
    always_comb
    begin
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a day step never coincides with the result capture
    a_step_capture: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.capture))
        else $error("step and capture in the same cycle");

    // a new result appears only at the end of a run
    a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RUN) && $past(sts.count_zero))
        else $error("result valid without a finished run");

    // a capture always leaves a valid result and frees the input
    a_capture_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> out_valid_reg && in_ready)
        else $error("capture did not present the result");

endmodule
`default_nettype wire

>>> sv/cda_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_dp
// Datapath: date registers, day counter, one-day step and result register.
// ----------------------------------------------------------------------------
module cda_dp (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cda_pkg::cmd_t            cmd,
    output cda_pkg::sts_t                 sts,
    input  wire logic                     load,
    input  wire logic [cda_pkg::YEAR_W-1:0]  load_year,
    input  wire logic [cda_pkg::MONTH_W-1:0] load_month,
    input  wire logic [cda_pkg::DAY_W-1:0]   load_day,
    input  wire logic [cda_pkg::CNT_W-1:0]   advance_days,
    input  wire cda_pkg::date_t           ref_date,
    output cda_pkg::date_t                res_date,
    output logic                          res_before,
    output logic                          res_after,
    output logic                          res_equal
);
    import cda_pkg::*;

    date_t            date_reg, date_next, stepped;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DAY_W-1:0] last_day;
    date_t            res_reg;
    logic             before_reg, after_reg, equal_reg;

    assign sts.count_zero = (cnt_reg == '0);
    assign res_date       = res_reg;
    assign res_before     = before_reg;
    assign res_after      = after_reg;
    assign res_equal      = equal_reg;

    // one day forward, with month and year rollover
    always_comb
    begin
        last_day = month_days(date_reg.month, is_leap(date_reg.year));
        stepped  = date_reg;
        if (date_reg.day < last_day)
        begin
            stepped.day = date_reg.day + DAY_FIRST;
        end
        else if (date_reg.month < MONTH_DEC)
        begin
            stepped.month = date_reg.month + MONTH_JAN;
            stepped.day   = DAY_FIRST;
        end
        else
        begin
            stepped.year  = (date_reg.year >= YEAR_LAST) ? '0 : date_reg.year + 14'd1;
            stepped.month = MONTH_JAN;
            stepped.day   = DAY_FIRST;
        end
    end

    // select the next date and count
    always_comb
    begin
        date_next = date_reg;
        cnt_next  = cnt_reg;
        if (cmd.start)
        begin
            if (load)
            begin
                date_next.year  = load_year;
                date_next.month = load_month;
                date_next.day   = load_day;
            end
            cnt_next = (advance_days > MAX_ADVANCE) ? MAX_ADVANCE : advance_days;
        end
        else if (cmd.step)
        begin
            date_next = stepped;
            cnt_next  = cnt_reg - 10'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg.year  <= 14'd2000;
            date_reg.month <= 4'd1;
            date_reg.day   <= 5'd1;
            cnt_reg        <= '0;
        end
        else
        begin
            date_reg <= date_next;
            cnt_reg  <= cnt_next;
        end
    end

    // capture the date and its order against the reference
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_reg    <= date_reg;
            before_reg <= (date_reg < ref_date);
            after_reg  <= (date_reg > ref_date);
            equal_reg  <= (date_reg == ref_date);
        end
    end

endmodule
`default_nettype wire

>>> sv/calendar_date_advance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_advance
// Gregorian date counter with comparison against a reference date.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : input items (optional date load, then a count of days to add).
//   out_ch : one result item per input item: new date and its order
//            against the reference date (before / after / equal, one-hot).
//   APB    : registers ref_year (0x0), ref_month (0x4), ref_day (0x8);
//            pready is always high, write only while the block is idle.
// Timing: an item with n days to add (n clamped to 1023) is accepted, then
//   takes n one-day steps in the datapath, then writes the result register
//   once out_ch is free; out_ch.valid rises with that write.
// in_ch.ready is high only while no item is in work. A finished result
//   waits in the output register; the next item is accepted meanwhile, and
//   its stepping completes, but its result waits until out_ch is free.
// Reset: date 2000-01-01, reference 2000-01-01, no result pending.
// ----------------------------------------------------------------------------
module calendar_date_advance (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cda_in_if.sink      in_ch,
    cda_out_if.source   out_ch,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready
);
    import cda_pkg::*;

    date_t ref_date;
    date_t res_date;
    cmd_t  cmd;
    sts_t  sts;
    logic  in_ready;
    logic  out_valid;
    logic  res_before, res_after, res_equal;

    // reference date registers
    cda_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .ref_date (ref_date)
    );

    // sequencing
    cda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // date arithmetic
    cda_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .load         (in_ch.load),
        .load_year    (in_ch.load_year),
        .load_month   (in_ch.load_month),
        .load_day     (in_ch.load_day),
        .advance_days (in_ch.advance_days),
        .ref_date     (ref_date),
        .res_date     (res_date),
        .res_before   (res_before),
        .res_after    (res_after),
        .res_equal    (res_equal)
    );

    // drive the channels
    assign in_ch.ready             = in_ready;
    assign out_ch.valid            = out_valid;
    assign out_ch.cur_year_out     = res_date.year;
    assign out_ch.cur_month_out    = res_date.month;
    assign out_ch.cur_day_out      = res_date.day;
    assign out_ch.before_reference = res_before;
    assign out_ch.after_reference  = res_after;
    assign out_ch.equal_reference  = res_equal;

endmodule
`default_nettype wire
